// File: rtl/inode_dedup_usage_accumulator_core_assert.svh
// Assertion macros for the checker of the inode usage accumulator.
// No dependencies; included by the checker file.
`ifndef INODE_DEDUP_USAGE_ACCUMULATOR_CORE_ASSERT_SVH
`define INODE_DEDUP_USAGE_ACCUMULATOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define IDDUA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle rule");

// Next-cycle implication, disabled while reset is held.
`define IDDUA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle rule");

// Next-cycle implication that is also checked across reset.
`define IDDUA_ASSERT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: reset rule");

`endif

// File: rtl/iddua_pkg.sv
// Shared constants, types and helpers of the inode usage accumulator.
// No dependencies; used by every RTL file of the block but iddua_ram.
package iddua_pkg;

    // Seen-set geometry. BUCKETS is a power of two: the bucket is taken from
    // the low bits of the inode number.
    localparam int BUCKETS = 128;
    localparam int WAYS    = 4;
    localparam int BKT_W   = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;

    // Field widths.
    localparam int CTX_W    = 32;
    localparam int LINKS_W  = 16;
    localparam int INODE_W  = 64;
    localparam int BLOCKS_W = 32;
    localparam int TOTAL_W  = 64;
    localparam int CFG_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int BLOCK_SHIFT = 9;

    // Input tdata layout, lowest field first.
    localparam int CTX_LSB    = 0;
    localparam int LINKS_LSB  = CTX_LSB + CTX_W;
    localparam int INODE_LSB  = LINKS_LSB + LINKS_W;
    localparam int BLOCKS_LSB = INODE_LSB + INODE_W;
    localparam int IN_DATA_W  = BLOCKS_LSB + BLOCKS_W;

    // One slot of a bucket word: valid bit above the inode tag.
    localparam int SLOT_W = INODE_W + 1;
    localparam int ROW_W  = SLOT_W * WAYS;

    // Divider sizing.
    localparam int DIVIDEND_W = TOTAL_W;
    localparam int DIVISOR_W  = CFG_W;
    localparam int DIV_CNT_W  = $clog2(DIVIDEND_W) + 1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_OWNER_CONTEXT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COUNT_MODE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = 2'd2;

    localparam logic [CFG_W-1:0] BLOCK_SIZE_RESET = 32'd1024;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_DIVIDE
    } t_state;

    // Result flags, counted in the lowest bit (tuser order).
    typedef struct packed {
        logic table_full;
        logic duplicate;
        logic counted;
    } t_flags;

    typedef struct packed {
        logic start;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    function automatic logic [BKT_W-1:0] bucket_of(input logic [INODE_W-1:0] ino);
        logic [BKT_W-1:0] b;
        b = (BUCKETS == 1) ? '0 : ino[BKT_W-1:0];
        return b;
    endfunction

endpackage

// File: rtl/iddua_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module iddua_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  logic [W-1:0]                         i_wdata,
    input  logic                                 i_re,
    input  logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic [W-1:0]                         o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/iddua_div.sv
// Restoring divider, one quotient bit per cycle, for the final byte total.
// Depends on iddua_pkg.
module iddua_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  iddua_pkg::t_div_ctl               i_ctl,
    input  logic [iddua_pkg::DIVIDEND_W-1:0]  i_dividend,
    input  logic [iddua_pkg::DIVISOR_W-1:0]   i_divisor,
    output iddua_pkg::t_div_sts               o_sts,
    output logic [iddua_pkg::DIVIDEND_W-1:0]  o_quotient
);

    logic [iddua_pkg::DIVISOR_W-1:0]  r_rem, n_rem;
    logic [iddua_pkg::DIVISOR_W-1:0]  r_dvs;
    logic [iddua_pkg::DIVIDEND_W-1:0] r_quo, n_quo;
    logic [iddua_pkg::DIV_CNT_W-1:0]  r_cnt;
    logic                             r_busy;
    logic                             r_done;
    logic [iddua_pkg::DIVISOR_W:0]    shifted;
    logic                             fits;

    // The dividend shifts out of the top of r_quo while quotient bits enter below.
    always_comb begin
        shifted = {r_rem, r_quo[iddua_pkg::DIVIDEND_W-1]};
        fits    = (shifted >= {1'b0, r_dvs});
        n_rem   = fits ? iddua_pkg::DIVISOR_W'(shifted - {1'b0, r_dvs})
                       : shifted[iddua_pkg::DIVISOR_W-1:0];
        n_quo   = {r_quo[iddua_pkg::DIVIDEND_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= iddua_pkg::DIV_CNT_W'(iddua_pkg::DIVIDEND_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == iddua_pkg::DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_quo <= i_dividend;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_quo;

endmodule

// File: rtl/inode_dedup_usage_accumulator_core.sv
// Top level of the inode usage accumulator: handshakes, seen-set lookup and totals.
// Depends on iddua_pkg, iddua_ram and iddua_div.
//
// Usage. Directory entries arrive one item at a time on the slave stream; tlast marks
// the final entry of one tree walk. Each item yields exactly one result item on the
// master stream: tuser carries the counted, duplicate and table_full flags, tdata the
// running total, and tlast marks the final total of the walk.
// Timing. The bucket word is read from the seen-set RAM at the edge that accepts an
// item. In the lookup step that follows, the word is compared, updated and written
// back, and the result is loaded into the output register, once that register is
// free. A new item is not taken until the previous write-back is done, so no
// forwarding is needed. A last item in space mode with a nonzero block size is
// written back without waiting for the output register, then runs the serial divider;
// its result is loaded once the divider is done and the output register is free.
// Reset (synchronous, active low) restores the configuration defaults, clears the
// running total and marks every bucket empty; the RAM itself is never cleared, since
// a per-bucket live bit masks stale contents. The last item of a walk clears the live
// bits and the running total. A stalled receiver holds the result in the output
// register; the block still takes one more item and then waits in its lookup step
// (or its divide step) until the output register frees up. The user must write
// configuration only while the block is idle; the block itself does not enforce it.
module inode_dedup_usage_accumulator_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Entry stream.
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // tdata, lowest bit up: entry_context, link_count, inode_number, block_count.
    input  logic [iddua_pkg::IN_DATA_W-1:0]     i_s_tdata,
    input  logic                                i_s_tlast,   // is_last
    // Result stream.
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // tdata: total.
    output logic [iddua_pkg::TOTAL_W-1:0]       o_m_tdata,
    // tuser, lowest bit up: counted, duplicate, table_full.
    output logic [2:0]                          o_m_tuser,
    output logic                                o_m_tlast,   // total_valid
    // Configuration writes.
    input  logic                                i_cfg_wr_en,
    input  logic [iddua_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [iddua_pkg::CFG_W-1:0]         i_cfg_data
);

    // Configuration registers.
    logic [iddua_pkg::CFG_W-1:0] r_cfg_owner;
    logic                        r_cfg_count_mode;
    logic [iddua_pkg::CFG_W-1:0] r_cfg_block_size;

    // Captured item.
    logic [iddua_pkg::CTX_W-1:0]    r_ctx;
    logic [iddua_pkg::LINKS_W-1:0]  r_links;
    logic [iddua_pkg::INODE_W-1:0]  r_inode;
    logic [iddua_pkg::BLOCKS_W-1:0] r_blocks;
    logic                           r_last;

    // Control and walk state.
    iddua_pkg::t_state              r_state, n_state;
    logic [iddua_pkg::BUCKETS-1:0]  r_row_valid;
    logic [iddua_pkg::TOTAL_W-1:0]  r_total;
    iddua_pkg::t_flags              r_flags;

    // Output register.
    logic                           r_out_valid;
    logic [iddua_pkg::TOTAL_W-1:0]  r_out_total;
    iddua_pkg::t_flags              r_out_flags;
    logic                           r_out_last;

    // Handshake and sequencing strobes.
    logic s_accept;
    logic ram_re;
    logic ram_we;
    logic commit;
    logic load_lookup;
    logic load_div;
    logic out_free;
    logic need_div;
    iddua_pkg::t_div_ctl div_ctl;
    iddua_pkg::t_div_sts div_sts;
    logic [iddua_pkg::TOTAL_W-1:0] div_quo;

    // Seen-set access.
    logic [iddua_pkg::INODE_W-1:0] s_inode;
    logic [iddua_pkg::BKT_W-1:0]   s_bucket;
    logic [iddua_pkg::BKT_W-1:0]   r_bucket;
    logic [iddua_pkg::ROW_W-1:0]   ram_rdata;
    logic [iddua_pkg::ROW_W-1:0]   row_wdata;

    // Lookup results.
    logic                          row_live;
    logic [iddua_pkg::WAYS-1:0]    slot_v;
    logic [iddua_pkg::WAYS-1:0]    slot_hit;
    logic [iddua_pkg::WAYS-1:0]    free_oh;
    logic                          ctx_ok;
    logic                          dedup;
    logic                          dup;
    logic                          write_slot;
    iddua_pkg::t_flags             flags;
    logic [iddua_pkg::TOTAL_W-1:0] addend;
    logic [iddua_pkg::TOTAL_W:0]   sum;
    logic [iddua_pkg::TOTAL_W-1:0] total_after;

    assign s_inode  = i_s_tdata[iddua_pkg::INODE_LSB +: iddua_pkg::INODE_W];
    assign s_bucket = iddua_pkg::bucket_of(s_inode);
    assign r_bucket = iddua_pkg::bucket_of(r_inode);
    assign s_accept = i_s_tvalid && o_s_tready;
    assign out_free = !r_out_valid || i_m_tready;
    assign need_div = !r_cfg_count_mode && (r_cfg_block_size != '0);

    iddua_ram #(
        .W (iddua_pkg::ROW_W),
        .D (iddua_pkg::BUCKETS)
    ) u_seen (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_bucket),
        .i_wdata (row_wdata),
        .i_re    (ram_re),
        .i_raddr (s_bucket),
        .o_rdata (ram_rdata)
    );

    iddua_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (div_ctl),
        .i_dividend (total_after),
        .i_divisor  (r_cfg_block_size),
        .o_sts      (div_sts),
        .o_quotient (div_quo)
    );

    // Bucket compare. A bucket not touched since the last clear reads as empty,
    // whatever the RAM holds. The lowest free way is the lowest zero of slot_v.
    always_comb begin
        row_live = r_row_valid[r_bucket];
        for (int w = 0; w < iddua_pkg::WAYS; w++) begin
            slot_v[w]   = row_live && ram_rdata[w*iddua_pkg::SLOT_W + iddua_pkg::INODE_W];
            slot_hit[w] = slot_v[w]
                && (ram_rdata[w*iddua_pkg::SLOT_W +: iddua_pkg::INODE_W] == r_inode);
        end
        free_oh    = ~slot_v & (slot_v + 1'b1);
        ctx_ok     = (r_ctx == r_cfg_owner);
        dedup      = ctx_ok && (r_links > iddua_pkg::LINKS_W'(1));
        dup        = |slot_hit;
        write_slot = dedup && !dup && (|free_oh);

        flags.counted    = ctx_ok && !(dedup && dup);
        flags.duplicate  = dedup && dup;
        flags.table_full = dedup && !dup && !(|free_oh);

        // Stale slots of a dead bucket are written back with their valid bits low.
        for (int w = 0; w < iddua_pkg::WAYS; w++) begin
            if (free_oh[w]) begin
                row_wdata[w*iddua_pkg::SLOT_W +: iddua_pkg::SLOT_W] = {1'b1, r_inode};
            end else begin
                row_wdata[w*iddua_pkg::SLOT_W +: iddua_pkg::SLOT_W] =
                    {slot_v[w], ram_rdata[w*iddua_pkg::SLOT_W +: iddua_pkg::INODE_W]};
            end
        end
    end

    // Saturating accumulate: one per entry in count mode, 512 bytes per block otherwise.
    always_comb begin
        if (r_cfg_count_mode) begin
            addend = iddua_pkg::TOTAL_W'(1);
        end else begin
            addend = {{(iddua_pkg::TOTAL_W - iddua_pkg::BLOCKS_W - iddua_pkg::BLOCK_SHIFT){1'b0}},
                      r_blocks, {iddua_pkg::BLOCK_SHIFT{1'b0}}};
        end
        sum = {1'b0, r_total} + {1'b0, addend};
        if (!flags.counted) begin
            total_after = r_total;
        end else if (sum[iddua_pkg::TOTAL_W]) begin
            total_after = '1;
        end else begin
            total_after = sum[iddua_pkg::TOTAL_W-1:0];
        end
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iddua_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        o_s_tready    = 1'b0;
        ram_re        = 1'b0;
        ram_we        = 1'b0;
        commit        = 1'b0;
        load_lookup   = 1'b0;
        load_div      = 1'b0;
        div_ctl.start = 1'b0;
        case (r_state)
            iddua_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                ram_re     = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = iddua_pkg::ST_LOOKUP;
                end
            end
            iddua_pkg::ST_LOOKUP: begin
                // The read data stays put while the output register is busy.
                if (r_last && need_div) begin
                    commit        = 1'b1;
                    ram_we        = write_slot;
                    div_ctl.start = 1'b1;
                    n_state       = iddua_pkg::ST_DIVIDE;
                end else if (out_free) begin
                    commit      = 1'b1;
                    ram_we      = write_slot;
                    load_lookup = 1'b1;
                    n_state     = iddua_pkg::ST_IDLE;
                end
            end
            iddua_pkg::ST_DIVIDE: begin
                if (div_sts.done && out_free) begin
                    load_div = 1'b1;
                    n_state  = iddua_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = iddua_pkg::ST_IDLE;
            end
        endcase
    end

    // Configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_owner      <= '0;
            r_cfg_count_mode <= 1'b0;
            r_cfg_block_size <= iddua_pkg::BLOCK_SIZE_RESET;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                iddua_pkg::CFG_OWNER_CONTEXT: r_cfg_owner      <= i_cfg_data;
                iddua_pkg::CFG_COUNT_MODE:    r_cfg_count_mode <= i_cfg_data[0];
                iddua_pkg::CFG_BLOCK_SIZE:    r_cfg_block_size <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_ctx    <= i_s_tdata[iddua_pkg::CTX_LSB +: iddua_pkg::CTX_W];
            r_links  <= i_s_tdata[iddua_pkg::LINKS_LSB +: iddua_pkg::LINKS_W];
            r_inode  <= s_inode;
            r_blocks <= i_s_tdata[iddua_pkg::BLOCKS_LSB +: iddua_pkg::BLOCKS_W];
            r_last   <= i_s_tlast;
        end
    end

    // Walk state. The end of a walk clears every live bit and the total at once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_total     <= '0;
        end else if (commit) begin
            if (r_last) begin
                r_row_valid <= '0;
                r_total     <= '0;
            end else begin
                if (write_slot) begin
                    r_row_valid[r_bucket] <= 1'b1;
                end
                r_total <= total_after;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_flags <= flags;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_lookup || load_div) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_lookup) begin
            r_out_total <= total_after;
            r_out_flags <= flags;
            r_out_last  <= r_last;
        end else if (load_div) begin
            r_out_total <= div_quo;
            r_out_flags <= r_flags;
            r_out_last  <= 1'b1;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_total;
    assign o_m_tuser  = r_out_flags;
    assign o_m_tlast  = r_out_last;

endmodule

// File: rtl/iddua_checker.sv
// Port-level checker for the inode usage accumulator, bound to the top level.
// Depends on inode_dedup_usage_accumulator_core_assert.svh and iddua_pkg.
`include "inode_dedup_usage_accumulator_core_assert.svh"

module iddua_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            o_s_tready,
    input logic [iddua_pkg::IN_DATA_W-1:0] i_s_tdata,
    input logic                            i_s_tlast,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [iddua_pkg::TOTAL_W-1:0]   o_m_tdata,
    input logic [2:0]                      o_m_tuser,
    input logic                            o_m_tlast,
    input logic                            i_cfg_wr_en,
    input logic [iddua_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input logic [iddua_pkg::CFG_W-1:0]     i_cfg_data
);

    iddua_pkg::t_flags out_flags;
    assign out_flags = o_m_tuser;

    // A stalled result holds its value.
    `IDDUA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))

    // One item in flight: the cycle after an accept is always a lookup.
    `IDDUA_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)

    // A repeat is never counted, and a full bucket still counts a new inode.
    `IDDUA_ASSERT_NOW(a_flag_mix, i_clk, i_rst_n, o_m_tvalid, !(out_flags.duplicate && out_flags.counted) && (!out_flags.table_full || (out_flags.counted && !out_flags.duplicate)))

    // Reset drops any pending result.
    `IDDUA_ASSERT_ALWAYS(a_reset_out, i_clk, !i_rst_n, !o_m_tvalid)

endmodule

bind inode_dedup_usage_accumulator_core iddua_checker u_iddua_checker (.*);
